// ===== hdl/aligned_stack_allocator_assert.svh =====
// Assertion macros for the stack allocator.
`ifndef ALIGNED_STACK_ALLOCATOR_ASSERT_SVH
`define ALIGNED_STACK_ALLOCATOR_ASSERT_SVH

// Clocked assertion, off while reset is asserted.
`define ASA_ASSERT_ON(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked assertion, checked during reset too.
`define ASA_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/asa_pkg.sv =====
package asa_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 64;
  localparam int unsigned OFFSET_BITS_DEF = 24;

  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned BUF_W     = 24;
  localparam int unsigned REQ_W     = 24;
  localparam int unsigned SIZE_W    = 25;
  localparam int unsigned COUNT_W   = 7;
  localparam int unsigned ALIGN_W   = 4;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 32;

  localparam int unsigned S_TDATA_W = 56;
  localparam int unsigned M_TDATA_W = 40;
  localparam int unsigned M_PAD_W   = M_TDATA_W - STATUS_W - ADDR_W;

  localparam logic [ADDR_W-1:0]  BASE_RST       = 32'h0000_0000;
  localparam logic [BUF_W-1:0]   BUF_SIZE_RST   = 24'h06_0000;
  localparam logic [COUNT_W-1:0] MAX_BLOCKS_RST = 7'd64;
  localparam logic [ALIGN_W-1:0] ALIGN_RST      = 4'd6;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BLOCKS   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALIGN_LOG2   = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_TABLE_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BUFFER_FULL = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND   = 2'd3;

  localparam logic KIND_RELEASE = 1'b1;

  typedef struct packed {
    logic load;
    logic calc_size;
    logic alloc;
    logic scan_step;
    logic rel_commit;
    logic out_load;
  } asa_cmd_t;

  typedef struct packed {
    logic is_release;
    logic scan_hit;
    logic scan_done;
    logic out_free;
  } asa_sts_t;

endpackage

// ===== hdl/asa_ram.sv =====
module asa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/asa_ctrl.sv =====
module asa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  asa_pkg::asa_sts_t sts_i,
  output asa_pkg::asa_cmd_t cmd_o
);
  import asa_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SIZE  = 3'd1;
  localparam logic [2:0] ST_ALLOC = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_REL   = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0] state_q, state_d;
  asa_cmd_t   cmd;

  always_comb begin
    cmd       = '0;
    s_ready_o = 1'b0;
    state_d   = state_q;
    case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd.load = 1'b1;
          state_d  = ST_SIZE;
        end
      end
      ST_SIZE: begin
        cmd.calc_size = 1'b1;
        state_d       = sts_i.is_release ? ST_SCAN : ST_ALLOC;
      end
      ST_ALLOC: begin
        cmd.alloc = 1'b1;
        state_d   = ST_DONE;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts_i.scan_hit) begin
          state_d = ST_REL;
        end else if (sts_i.scan_done) begin
          state_d = ST_DONE;
        end
      end
      ST_REL: begin
        cmd.rel_commit = 1'b1;
        state_d        = ST_DONE;
      end
      ST_DONE: begin
        // wait for the output register to free up
        if (sts_i.out_free) begin
          cmd.out_load = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o = cmd;

endmodule

// ===== hdl/asa_dp.sv =====
module asa_dp #(
  parameter int unsigned TABLE_DEPTH = asa_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned OFFSET_BITS = asa_pkg::OFFSET_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [asa_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [asa_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic [asa_pkg::S_TDATA_W-1:0]   s_tdata_i,
  input  logic                            s_tuser_i,
  input  logic                            m_tready_i,
  output logic                            m_tvalid_o,
  output logic [asa_pkg::M_TDATA_W-1:0]   m_tdata_o,
  input  asa_pkg::asa_cmd_t               cmd_i,
  output asa_pkg::asa_sts_t               sts_o
);
  import asa_pkg::*;

  localparam int unsigned IDX_W   = $clog2(TABLE_DEPTH);
  localparam int unsigned LIM_W   = (COUNT_W > IDX_W + 1) ? COUNT_W : IDX_W + 1;
  localparam int unsigned CALC_W  = ((OFFSET_BITS > SIZE_W) ? OFFSET_BITS : SIZE_W) + 1;
  localparam int unsigned ENTRY_W = OFFSET_BITS + SIZE_W;

  // configuration
  logic [ADDR_W-1:0]  base_q;
  logic [BUF_W-1:0]   buf_size_q;
  logic [COUNT_W-1:0] max_blocks_q;
  logic [ALIGN_W-1:0] align_q;

  // captured item
  logic               kind_q;
  logic [REQ_W-1:0]   req_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [SIZE_W-1:0]  size_q;

  // allocator state
  logic [OFFSET_BITS-1:0] top_q;
  logic [COUNT_W-1:0]     count_q;
  logic [TABLE_DEPTH-1:0] valid_q;

  // scan
  logic [IDX_W:0]     rd_idx_q;
  logic               pend_vld_q;
  logic [IDX_W-1:0]   pend_idx_q;
  logic [IDX_W-1:0]   hit_idx_q;
  logic [SIZE_W-1:0]  hit_size_q;

  // result and output register
  logic [STATUS_W-1:0]  res_status_q;
  logic [ADDR_W-1:0]    res_granted_q;
  logic                 m_valid_q;
  logic [M_TDATA_W-1:0] m_data_q;

  logic [LIM_W-1:0]       lim;
  logic [LIM_W-1:0]       count_ext;
  logic [SIZE_W-1:0]      align_mask;
  logic [SIZE_W-1:0]      size_d;
  logic [CALC_W-1:0]      alloc_sum;
  logic                   tbl_full;
  logic                   buf_full;
  logic                   alloc_ok;
  logic [IDX_W-1:0]       waddr;
  logic [ENTRY_W-1:0]     wdata;
  logic [ENTRY_W-1:0]     rdata;
  logic [OFFSET_BITS-1:0] ent_offset;
  logic [SIZE_W-1:0]      ent_size;
  logic                   rd_more;
  logic                   issue;
  logic [IDX_W-1:0]       raddr;
  logic                   hit;
  logic [CALC_W-1:0]      top_w;
  logic [CALC_W-1:0]      hsize_w;
  logic [OFFSET_BITS-1:0] rel_top;
  logic                   out_free;

  // table limit is max_blocks clamped to the table depth
  always_comb begin
    lim = LIM_W'(max_blocks_q);
    if (lim > LIM_W'(TABLE_DEPTH)) begin
      lim = LIM_W'(TABLE_DEPTH);
    end
  end

  assign count_ext  = LIM_W'(count_q);
  assign align_mask = (SIZE_W'(1) << align_q) - SIZE_W'(1);
  assign size_d     = (SIZE_W'(req_q) + align_mask) & ~align_mask;

  assign alloc_sum = CALC_W'(top_q) + CALC_W'(size_q);
  assign tbl_full  = count_ext >= lim;
  assign buf_full  = alloc_sum >= CALC_W'(buf_size_q);
  assign alloc_ok  = cmd_i.alloc && !tbl_full && !buf_full;

  assign waddr = count_ext[IDX_W-1:0];
  assign wdata = {size_q, top_q};

  assign rd_more = LIM_W'(rd_idx_q) < lim;
  assign raddr   = rd_idx_q[IDX_W-1:0];

  asa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (alloc_ok),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign ent_offset = rdata[OFFSET_BITS-1:0];
  assign ent_size   = rdata[ENTRY_W-1:OFFSET_BITS];

  // read data belongs to the entry issued on the previous scan step
  assign hit = pend_vld_q && valid_q[pend_idx_q] &&
               ((base_q + ADDR_W'(ent_offset)) == addr_q);
  assign issue = cmd_i.scan_step && rd_more && !hit;

  assign top_w   = CALC_W'(top_q);
  assign hsize_w = CALC_W'(hit_size_q);
  assign rel_top = (hsize_w > top_w) ? '0 : OFFSET_BITS'(top_w - hsize_w);

  assign out_free = !m_valid_q || m_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q       <= BASE_RST;
      buf_size_q   <= BUF_SIZE_RST;
      max_blocks_q <= MAX_BLOCKS_RST;
      align_q      <= ALIGN_RST;
      top_q        <= '0;
      count_q      <= '0;
      valid_q      <= '0;
      rd_idx_q     <= '0;
      pend_vld_q   <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_BASE_ADDRESS: base_q       <= cfg_data_i[ADDR_W-1:0];
          REG_BUFFER_SIZE:  buf_size_q   <= cfg_data_i[BUF_W-1:0];
          REG_MAX_BLOCKS:   max_blocks_q <= cfg_data_i[COUNT_W-1:0];
          REG_ALIGN_LOG2:   align_q      <= cfg_data_i[ALIGN_W-1:0];
          default: ;
        endcase
      end

      if (cmd_i.load) begin
        rd_idx_q   <= '0;
        pend_vld_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        pend_vld_q <= issue;
        if (issue) begin
          rd_idx_q <= rd_idx_q + (IDX_W+1)'(1);
        end
      end

      if (alloc_ok) begin
        valid_q[waddr] <= 1'b1;
        top_q          <= OFFSET_BITS'(alloc_sum);
        count_q        <= count_q + COUNT_W'(1);
      end else if (cmd_i.rel_commit) begin
        valid_q[hit_idx_q] <= 1'b0;
        top_q              <= rel_top;
        if (count_q != '0) begin
          count_q <= count_q - COUNT_W'(1);
        end
      end

      if (cmd_i.out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q        <= s_tuser_i;
      req_q         <= s_tdata_i[REQ_W-1:0];
      addr_q        <= s_tdata_i[REQ_W +: ADDR_W];
      res_status_q  <= STATUS_NOT_FOUND;
      res_granted_q <= '0;
    end
    if (cmd_i.calc_size) begin
      size_q <= size_d;
    end
    if (cmd_i.scan_step) begin
      pend_idx_q <= raddr;
      if (hit) begin
        hit_idx_q  <= pend_idx_q;
        hit_size_q <= ent_size;
      end
    end
    if (cmd_i.alloc) begin
      if (tbl_full) begin
        res_status_q <= STATUS_TABLE_FULL;
      end else if (buf_full) begin
        res_status_q <= STATUS_BUFFER_FULL;
      end else begin
        res_status_q  <= STATUS_OK;
        res_granted_q <= base_q + ADDR_W'(top_q);
      end
    end
    if (cmd_i.rel_commit) begin
      res_status_q <= STATUS_OK;
    end
    if (cmd_i.out_load) begin
      m_data_q <= {{M_PAD_W{1'b0}}, res_granted_q, res_status_q};
    end
  end

  assign sts_o.is_release = (kind_q == KIND_RELEASE);
  assign sts_o.scan_hit   = hit;
  assign sts_o.scan_done  = !pend_vld_q && !rd_more;
  assign sts_o.out_free   = out_free;

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;

endmodule

// ===== hdl/aligned_stack_allocator.sv =====
// Allocation: the item is captured, its size aligned up, the block allocated and the result loaded.
// Release: the block table is read one entry per cycle from a single RAM read port;
//   a hit releases that entry; a miss ends the scan after min(max_blocks, TABLE_DEPTH) entries.
//   Either way, the next item is taken only once the result is in the output register.
// The output register lets a new item enter while a result waits to be taken.
// Reset clears top, live count and valid bits and loads config defaults; table RAM is kept.
module aligned_stack_allocator #(
  parameter int unsigned TABLE_DEPTH = asa_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned OFFSET_BITS = asa_pkg::OFFSET_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [asa_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [asa_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [23:0] request_size, [55:24] block_address
  input  logic [asa_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // [0] kind
  input  logic [0:0]                    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [1:0] status, [33:2] granted_address, [39:34] zero
  output logic [asa_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import asa_pkg::*;

  asa_cmd_t cmd;
  asa_sts_t sts;

  asa_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  asa_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser[0]),
    .m_tready_i (m_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tdata_o  (m_axis_tdata),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule

// ===== hdl/asa_checker.sv =====
`include "aligned_stack_allocator_assert.svh"

module asa_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [asa_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import asa_pkg::*;

  // one item at a time: input closes right after an item is taken
  `ASA_ASSERT_ON(a_one_item, clk_i, rst_ni, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "item accepted while busy")

  // a stalled result holds
  `ASA_ASSERT_ON(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result dropped or changed under stall")

  // only a successful allocation carries an address
  `ASA_ASSERT_ON(a_fail_zero, clk_i, rst_ni, m_axis_tvalid && (m_axis_tdata[STATUS_W-1:0] != STATUS_OK) |-> m_axis_tdata[STATUS_W +: ADDR_W] == '0, "address on failed request")

  // once reset is seen, no result shows on the next edge
  `ASA_ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |=> !m_axis_tvalid, "result valid during reset")

endmodule

bind aligned_stack_allocator asa_checker u_asa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
